// ----- rtl/core/nested_action_record_indexer_macros.svh -----
// ----------------------------------------------------------------------------
// nested action record indexer assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef NESTED_ACTION_RECORD_INDEXER_MACROS_SVH
`define NESTED_ACTION_RECORD_INDEXER_MACROS_SVH

// implication checked in the following cycle, quiet while in reset
`define NARI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, quiet while in reset
`define NARI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the following cycle, also across reset
`define NARI_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/nari_pkg.sv -----
// ----------------------------------------------------------------------------
// nari_pkg
// shared types and constants of the nested action record indexer
// ----------------------------------------------------------------------------
`default_nettype none

package nari_pkg;

  localparam int MAX_ACTIONS_DEF = 40;
  localparam int MAX_STRINGS_DEF = 64;
  localparam int MAX_DEPTH_DEF   = 8;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 16;
  localparam int IDX_W    = 6;
  localparam int CHILD_W  = 6;
  localparam int HSKIP_W  = 3;
  localparam int QDEPTH   = 2;

  localparam logic [7:0] HEAD_CLASS_MASK = 8'hc0;
  localparam logic [7:0] HEAD_GROUP      = 8'h40;
  localparam logic [7:0] HEAD_SINGLE     = 8'h00;
  localparam logic [7:0] HEAD_VAR_MASK   = 8'hf8;
  localparam logic [7:0] HEAD_VAR        = 8'h80;
  localparam logic [7:0] HEAD_TWO        = 8'h91;
  localparam logic [7:0] HEAD_ONE_MASK   = 8'hfc;
  localparam logic [7:0] HEAD_ONE        = 8'h88;
  localparam logic [7:0] ACTIONS_END     = 8'hfe;
  localparam logic [7:0] DATA_END        = 8'hff;

  typedef enum logic [2:0] {
    KIND_ACTION    = 3'd0,
    KIND_STRING    = 3'd1,
    KIND_ACT_END   = 3'd2,
    KIND_DATA_END  = 3'd3,
    KIND_NEST_OVF  = 3'd4,
    KIND_COUNT_OVF = 3'd5
  } kind_t;

  typedef struct packed {
    logic                restart;
    logic [BYTE_W-1:0]   blob_byte;
    logic                is_group;
    logic                grp_zero;
    logic                is_fe;
    logic                is_ff;
    logic [HSKIP_W-1:0]  head_skip;
  } head_t;

endpackage

`default_nettype wire

// ----- rtl/core/nari_front.sv -----
// ----------------------------------------------------------------------------
// nari_front
// accepts blob bytes, classifies action heads and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module nari_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_blob_byte,
  input  wire logic           in_restart,
  output logic                q_valid,
  output nari_pkg::head_t     q_item,
  input  wire logic           q_pop
);

  nari_pkg::head_t cls;
  nari_pkg::head_t ent_r [nari_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       pop;

  always_comb begin
    cls           = '0;
    cls.restart   = in_restart;
    cls.blob_byte = in_blob_byte;
    cls.is_fe     = (in_blob_byte == nari_pkg::ACTIONS_END);
    cls.is_ff     = (in_blob_byte == nari_pkg::DATA_END);
    if ((in_blob_byte & nari_pkg::HEAD_CLASS_MASK) == nari_pkg::HEAD_GROUP) begin
      cls.is_group = 1'b1;
      cls.grp_zero = (in_blob_byte[5:0] == 6'd0);
    end else if ((in_blob_byte & nari_pkg::HEAD_CLASS_MASK) == nari_pkg::HEAD_SINGLE) begin
      cls.head_skip = 3'd0;
    end else if ((in_blob_byte & nari_pkg::HEAD_VAR_MASK) == nari_pkg::HEAD_VAR) begin
      cls.head_skip = in_blob_byte[2:0];
    end else if (in_blob_byte == nari_pkg::HEAD_TWO) begin
      cls.head_skip = 3'd2;
    end else if ((in_blob_byte & nari_pkg::HEAD_ONE_MASK) == nari_pkg::HEAD_ONE) begin
      cls.head_skip = 3'd1;
    end
  end

  assign in_tready = (fill_r != 2'(nari_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_item    = ent_r[rd_ptr_r];
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nari_back.sv -----
// ----------------------------------------------------------------------------
// nari_back
// parse state, nesting counter stack and result register
// ----------------------------------------------------------------------------
`default_nettype none

module nari_back #(
  parameter int MAX_ACTIONS = nari_pkg::MAX_ACTIONS_DEF,
  parameter int MAX_STRINGS = nari_pkg::MAX_STRINGS_DEF,
  parameter int MAX_DEPTH   = nari_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire nari_pkg::head_t             q_item,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output nari_pkg::kind_t                  out_kind,
  output logic [nari_pkg::POS_W-1:0]       out_offset,
  output logic [nari_pkg::IDX_W-1:0]       out_index
);

  localparam int AW = $clog2(MAX_ACTIONS + 1);
  localparam int SW = $clog2(MAX_STRINGS + 1);
  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_ACT,
    PH_STR,
    PH_STOP
  } phase_t;

  phase_t                       phase_r, phase_nxt, eff_phase;
  logic [nari_pkg::POS_W-1:0]   pos_r, pos_nxt, eff_pos;
  logic [7:0]                   skip_r, skip_nxt, eff_skip;
  logic [DW-1:0]                depth_r, depth_nxt, eff_depth, pop_depth;
  logic [AW-1:0]                act_r, act_nxt, eff_act;
  logic [SW-1:0]                str_r, str_nxt, eff_str;
  logic [nari_pkg::CHILD_W-1:0] cnt_r [MAX_DEPTH];

  logic                         out_valid_r;
  nari_pkg::kind_t              out_kind_r;
  logic [nari_pkg::POS_W-1:0]   out_off_r;
  logic [nari_pkg::IDX_W-1:0]   out_idx_r;

  logic                         res_valid;
  nari_pkg::kind_t              res_kind;
  logic [nari_pkg::IDX_W-1:0]   res_idx;
  logic                         take_head;
  logic                         do_push;
  logic                         do_complete;
  logic                         pop;

  assign pop   = q_valid && (!out_valid_r || out_tready);
  assign q_pop = pop;

  always_comb begin
    eff_phase = q_item.restart ? PH_ACT : phase_r;
    eff_pos   = q_item.restart ? '0 : pos_r;
    eff_skip  = q_item.restart ? '0 : skip_r;
    eff_depth = q_item.restart ? '0 : depth_r;
    eff_act   = q_item.restart ? '0 : act_r;
    eff_str   = q_item.restart ? '0 : str_r;
  end

  // level left after one action completes: highest live level not at its last child
  always_comb begin
    pop_depth = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (DW'(i) < eff_depth && cnt_r[i] != nari_pkg::CHILD_W'(1)) begin
        pop_depth = DW'(i + 1);
      end
    end
  end

  always_comb begin
    phase_nxt   = eff_phase;
    pos_nxt     = eff_pos + nari_pkg::POS_W'(1);
    skip_nxt    = eff_skip;
    depth_nxt   = eff_depth;
    act_nxt     = eff_act;
    str_nxt     = eff_str;
    res_valid   = 1'b0;
    res_kind    = nari_pkg::KIND_ACTION;
    res_idx     = '0;
    take_head   = 1'b0;
    do_push     = 1'b0;
    do_complete = 1'b0;
    if (eff_phase != PH_STOP && eff_skip != 8'd0) begin
      skip_nxt = eff_skip - 8'd1;
    end else begin
      case (eff_phase)
        PH_ACT: begin
          if (eff_depth == '0) begin
            if (q_item.is_fe) begin
              phase_nxt = PH_STR;
              res_valid = 1'b1;
              res_kind  = nari_pkg::KIND_ACT_END;
              res_idx   = nari_pkg::IDX_W'(eff_act);
            end else if (eff_act >= AW'(MAX_ACTIONS)) begin
              phase_nxt = PH_STOP;
              res_valid = 1'b1;
              res_kind  = nari_pkg::KIND_COUNT_OVF;
              res_idx   = nari_pkg::IDX_W'(eff_act);
            end else begin
              res_valid = 1'b1;
              res_kind  = nari_pkg::KIND_ACTION;
              res_idx   = nari_pkg::IDX_W'(eff_act);
              act_nxt   = eff_act + AW'(1);
              take_head = 1'b1;
            end
          end else begin
            take_head = 1'b1;
          end
        end
        PH_STR: begin
          if (q_item.is_ff) begin
            phase_nxt = PH_STOP;
            res_valid = 1'b1;
            res_kind  = nari_pkg::KIND_DATA_END;
            res_idx   = nari_pkg::IDX_W'(eff_str);
          end else if (eff_str >= SW'(MAX_STRINGS)) begin
            phase_nxt = PH_STOP;
            res_valid = 1'b1;
            res_kind  = nari_pkg::KIND_COUNT_OVF;
            res_idx   = nari_pkg::IDX_W'(eff_str);
          end else begin
            res_valid = 1'b1;
            res_kind  = nari_pkg::KIND_STRING;
            res_idx   = nari_pkg::IDX_W'(eff_str);
            str_nxt   = eff_str + SW'(1);
            skip_nxt  = q_item.blob_byte;
          end
        end
        default: begin
        end
      endcase
    end
    if (take_head) begin
      if (q_item.is_group && !q_item.grp_zero) begin
        if (eff_depth >= DW'(MAX_DEPTH)) begin
          phase_nxt = PH_STOP;
          res_valid = 1'b1;
          res_kind  = nari_pkg::KIND_NEST_OVF;
          res_idx   = nari_pkg::IDX_W'(eff_act);
        end else begin
          do_push   = 1'b1;
          depth_nxt = eff_depth + DW'(1);
        end
      end else begin
        skip_nxt    = {5'd0, q_item.head_skip};
        do_complete = 1'b1;
        depth_nxt   = pop_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ACT;
      pos_r       <= '0;
      skip_r      <= '0;
      depth_r     <= '0;
      act_r       <= '0;
      str_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        skip_r  <= skip_nxt;
        depth_r <= depth_nxt;
        act_r   <= act_nxt;
        str_r   <= str_nxt;
      end
      if (pop && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_kind_r <= res_kind;
      out_off_r  <= eff_pos;
      out_idx_r  <= res_idx;
    end
  end

  // child counter stack, one register per level
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (pop && do_push && DW'(i) == eff_depth) begin
        cnt_r[i] <= q_item.blob_byte[nari_pkg::CHILD_W-1:0];
      end else if (pop && do_complete && DW'(i + 1) == pop_depth) begin
        cnt_r[i] <= cnt_r[i] - nari_pkg::CHILD_W'(1);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_offset = out_off_r;
  assign out_index  = out_idx_r;

endmodule

`default_nettype wire

// ----- rtl/core/nested_action_record_indexer.sv -----
// ----------------------------------------------------------------------------
// nested_action_record_indexer
// byte stream indexer for action records and length-prefixed strings
// ----------------------------------------------------------------------------
// One blob byte enters per cycle and the block sustains one byte per clock,
// including payload and string bytes that give no result. A byte passes a
// classifier and a two-entry queue, then the parse stage, which resolves the
// whole nesting counter stack (push or cascaded pop) as it takes the byte;
// a result sits in an output register behind the queue and shows on
// out_tvalid from there, and waits while an earlier result is not taken. A
// stalled output stalls the parse stage, and the queue fills with up to two
// bytes before in_tready drops. A byte with the restart flag clears the parse
// state and is taken as offset zero.
`default_nettype none

module nested_action_record_indexer #(
  parameter int MAX_ACTIONS = nari_pkg::MAX_ACTIONS_DEF,
  parameter int MAX_STRINGS = nari_pkg::MAX_STRINGS_DEF,
  parameter int MAX_DEPTH   = nari_pkg::MAX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // blob_byte
  input  wire logic [0:0]  in_tuser,   // restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // offset, record_index, zero pad
  output logic [2:0]       out_tuser   // kind
);

  logic                       q_valid;
  logic                       q_pop;
  nari_pkg::head_t            q_item;
  nari_pkg::kind_t            kind;
  logic [nari_pkg::POS_W-1:0] offset;
  logic [nari_pkg::IDX_W-1:0] record_index;

  nari_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_blob_byte (in_tdata),
    .in_restart   (in_tuser[0]),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  nari_back #(
    .MAX_ACTIONS (MAX_ACTIONS),
    .MAX_STRINGS (MAX_STRINGS),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (kind),
    .out_offset (offset),
    .out_index  (record_index)
  );

  assign out_tdata = {2'b00, record_index, offset};
  assign out_tuser = kind;

endmodule

`default_nettype wire

// ----- rtl/core/nari_checker.sv -----
// ----------------------------------------------------------------------------
// nari_checker
// port-level checks of the nested action record indexer
// ----------------------------------------------------------------------------
`default_nettype none

`include "nested_action_record_indexer_macros.svh"

module nari_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata != 8'h00 || in_tuser != 1'b0);

  `NARI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `NARI_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid && in_tready, "not empty after reset")
  `NARI_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[23:22] == 2'b00, "pad bits set")
  `NARI_ASSERT_NEXT(a_no_spurious, !in_tvalid && !out_tvalid && in_tready && $past(in_tready) && !$past(in_tvalid) && !$past(out_tvalid) && !in_seen, !out_tvalid, "result with no byte in flight")

endmodule

bind nested_action_record_indexer nari_checker u_nari_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- sim/nested_action_record_indexer_checker.sv -----
// ----------------------------------------------------------------------------
// nested_action_record_indexer_checker
// watches both streams, tracks the parse state of the indexer from the items
// it takes and compares every result item with the oldest one predicted
// ----------------------------------------------------------------------------
module nested_action_record_indexer_checker
  import nari_pkg::*;
#(
  parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
  parameter int MAX_STRINGS = MAX_STRINGS_DEF,
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SEC_ACTIONS,
    SEC_STRINGS,
    SEC_HALTED
  } section_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] offset;
    logic [IDX_W-1:0] index;
  } index_rec_t;

  section_t           section;
  logic [POS_W-1:0]   byte_pos;
  logic [7:0]         skip_cnt;
  logic [CHILD_W-1:0] kids_left [MAX_DEPTH];
  int                 nest;
  int                 actions_seen;
  int                 strings_seen;

  index_rec_t         rec_q [$];
  index_rec_t         want;
  index_rec_t         fresh;
  bit                 fresh_hit;
  int                 errs = 0;

  function automatic void clear_parse();
    section      = SEC_ACTIONS;
    byte_pos     = '0;
    skip_cnt     = '0;
    nest         = 0;
    actions_seen = 0;
    strings_seen = 0;
    foreach (kids_left[i]) kids_left[i] = '0;
  endfunction

  // one record done at the current level: unwind every group it finishes
  function automatic void close_record();
    while (nest > 0) begin
      kids_left[nest-1] = kids_left[nest-1] - 1'b1;
      if (kids_left[nest-1] != '0) break;
      nest--;
    end
  endfunction

  function automatic bit open_head(input logic [7:0] b);
    if ((b & HEAD_CLASS_MASK) == HEAD_GROUP) begin
      if (b[5:0] == '0) begin
        close_record();
        return 1'b1;
      end
      if (nest >= MAX_DEPTH) return 1'b0;
      kids_left[nest] = b[CHILD_W-1:0];
      nest++;
      return 1'b1;
    end
    if ((b & HEAD_CLASS_MASK) == HEAD_SINGLE) skip_cnt = 8'd0;
    else if ((b & HEAD_VAR_MASK) == HEAD_VAR) skip_cnt = {5'd0, b[2:0]};
    else if (b == HEAD_TWO) skip_cnt = 8'd2;
    else if ((b & HEAD_ONE_MASK) == HEAD_ONE) skip_cnt = 8'd1;
    close_record();
    return 1'b1;
  endfunction

  function automatic index_rec_t make_rec(input kind_t k, input logic [POS_W-1:0] off,
                                          input int count);
    index_rec_t r;
    r.kind   = k;
    r.offset = off;
    r.index  = count[IDX_W-1:0];
    return r;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic rs,
                                       output bit hit, output index_rec_t rec);
    logic [POS_W-1:0] off;
    hit = 1'b0;
    rec = '0;
    if (rs) clear_parse();
    off      = byte_pos;
    byte_pos = byte_pos + 1'b1;
    if (section == SEC_HALTED) return;
    if (skip_cnt != 8'd0) begin
      skip_cnt--;
      return;
    end
    hit = 1'b1;
    if (section == SEC_ACTIONS) begin
      if (nest == 0) begin
        if (b == ACTIONS_END) begin
          section = SEC_STRINGS;
          rec     = make_rec(KIND_ACT_END, off, actions_seen);
        end else if (actions_seen >= MAX_ACTIONS) begin
          section = SEC_HALTED;
          rec     = make_rec(KIND_COUNT_OVF, off, actions_seen);
        end else begin
          rec = make_rec(KIND_ACTION, off, actions_seen);
          actions_seen++;
          void'(open_head(b));
        end
      end else if (!open_head(b)) begin
        section = SEC_HALTED;
        rec     = make_rec(KIND_NEST_OVF, off, actions_seen);
      end else begin
        hit = 1'b0;
      end
    end else if (b == DATA_END) begin
      section = SEC_HALTED;
      rec     = make_rec(KIND_DATA_END, off, strings_seen);
    end else if (strings_seen >= MAX_STRINGS) begin
      section = SEC_HALTED;
      rec     = make_rec(KIND_COUNT_OVF, off, strings_seen);
    end else begin
      rec = make_rec(KIND_STRING, off, strings_seen);
      strings_seen++;
      skip_cnt = b;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      rec_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata, in_tuser[0], fresh_hit, fresh);
        if (fresh_hit) rec_q.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        if (rec_q.size() == 0) begin
          $error("unexpected result: kind %0d offset %0d index %0d", out_tuser,
                 out_tdata[POS_W-1:0], out_tdata[POS_W+IDX_W-1:POS_W]);
          errs++;
        end else begin
          want = rec_q.pop_front();
          if (out_tuser != want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
            errs++;
          end
          if (out_tdata[POS_W-1:0] != want.offset) begin
            $error("offset: expected %0d, actual %0d", want.offset,
                   out_tdata[POS_W-1:0]);
            errs++;
          end
          if (out_tdata[POS_W+IDX_W-1:POS_W] != want.index) begin
            $error("record_index: expected %0d, actual %0d", want.index,
                   out_tdata[POS_W+IDX_W-1:POS_W]);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= rec_q.size();
  end

endmodule

// ----- sim/nested_action_record_indexer_tb.sv -----
// ----------------------------------------------------------------------------
// nested_action_record_indexer_tb
// feeds blobs to the indexer: a short hand-written blob, then random
// well-formed, truncated and overflowing blobs with random gaps and output
// stalls; the checker does the comparing
// ----------------------------------------------------------------------------
module nested_action_record_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nari_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_LIMIT  = 5000;

  localparam logic [7:0] DIRECTED_BYTES [27] = '{
    8'h00, 8'h40, 8'h87, 8'hff, 8'hfe, 8'h00, 8'h41, 8'h91, 8'hff, 8'h7f,
    8'h91, 8'hfe, 8'hff, 8'h8b, 8'h91, 8'h80, 8'hc5, 8'h42, 8'hfe, 8'h3f,
    8'hfe, 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, 8'h12
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic [0:0]  in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int          sent_count = 0;
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  bit          hold_req   = 1'b0;

  // each entry: restart flag above the byte
  logic [8:0]  blob_q [$];

  nested_action_record_indexer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  nested_action_record_indexer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int lag;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        lag = HOLD_CYCLES;
      end else begin
        lag = rx_idle ? gap_len() : 0;
      end
      if (lag == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (lag) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b);
    blob_q.push_back({1'b0, b});
  endfunction

  function automatic void push_head(input logic [7:0] h);
    int n;
    push_byte(h);
    if ((h & HEAD_VAR_MASK) == HEAD_VAR) n = h[2:0];
    else if (h == HEAD_TWO) n = 2;
    else if ((h & HEAD_ONE_MASK) == HEAD_ONE) n = 1;
    else n = 0;
    repeat (n) push_byte(8'($urandom));
  endfunction

  function automatic logic [7:0] rand_head(input bit allow_group, input bit nested);
    logic [7:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2: h = {2'b00, 6'($urandom)};
      3, 4: begin
        if (allow_group) h = {2'b01, 6'($urandom_range(0, nested ? 2 : 4))};
        else h = {2'b00, 6'($urandom)};
      end
      5: h = {5'b10000, 3'($urandom)};
      6: h = HEAD_TWO;
      7: h = {6'b100010, 2'($urandom)};
      8: begin
        case ($urandom_range(0, 2))
          0: h = {2'b11, 6'($urandom)};
          1: h = {6'b100011, 2'($urandom)};
          default: h = {3'b101, 5'($urandom)};
        endcase
      end
      default: h = nested ? ACTIONS_END : DATA_END;
    endcase
    if (!nested && h == ACTIONS_END) h = 8'hc0;
    return h;
  endfunction

  function automatic void add_action(input int max_nest);
    int kids [$];
    logic [7:0] h;
    h = rand_head(max_nest > 0, 1'b0);
    push_head(h);
    if ((h & HEAD_CLASS_MASK) == HEAD_GROUP && h[5:0] != 0) kids.push_back(h[5:0]);
    while (kids.size() != 0) begin
      h = rand_head(kids.size() < max_nest, 1'b1);
      push_head(h);
      kids[kids.size()-1] = kids[kids.size()-1] - 1;
      if ((h & HEAD_CLASS_MASK) == HEAD_GROUP && h[5:0] != 0) kids.push_back(h[5:0]);
      while (kids.size() != 0 && kids[kids.size()-1] == 0) void'(kids.pop_back());
    end
  endfunction

  function automatic void add_strings(input int n);
    int len;
    repeat (n) begin
      len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(200, 255))
                                         : int'($urandom_range(0, 6));
      push_byte(8'(len));
      repeat (len) push_byte(8'($urandom));
    end
  endfunction

  function automatic void add_wellformed();
    int n;
    n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, MAX_ACTIONS_DEF))
                                    : int'($urandom_range(0, 6));
    repeat (n) add_action(int'($urandom_range(0, MAX_DEPTH_DEF)));
    push_byte(ACTIONS_END);
    add_strings(int'($urandom_range(0, 5)));
    if ($urandom_range(0, 9) != 0) push_byte(DATA_END);
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
  endfunction

  // a chain of groups to full depth, then either a leaf or one group too many
  function automatic void add_deep(input bit overflow);
    repeat (MAX_DEPTH_DEF) push_byte({2'b01, 6'd1});
    if (overflow) push_byte({2'b01, 6'($urandom_range(1, 63))});
    else push_byte(8'h05);
    push_byte(ACTIONS_END);
    push_byte(8'h01);
    push_byte(8'h33);
    push_byte(DATA_END);
  endfunction

  function automatic void add_many_actions();
    repeat (MAX_ACTIONS_DEF) push_byte({2'b00, 6'($urandom)});
    if ($urandom_range(0, 1) == 0) begin
      push_byte(ACTIONS_END);
      add_strings(2);
      push_byte(DATA_END);
    end else begin
      push_head(rand_head(1'b1, 1'b0));
      push_byte(ACTIONS_END);
    end
  endfunction

  function automatic void add_many_strings();
    push_byte(ACTIONS_END);
    repeat (MAX_STRINGS_DEF) push_byte(8'd0);
    if ($urandom_range(0, 1) == 0) push_byte(DATA_END);
    else push_byte(8'($urandom_range(0, 254)));
    push_byte(8'($urandom));
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(8, 40))
      blob_q.push_back({($urandom_range(0, 11) == 0), 8'($urandom)});
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = tx_idle ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_blob(input bit with_restart);
    foreach (blob_q[i]) send_byte(blob_q[i][7:0], blob_q[i][8] || (with_restart && i == 0));
    blob_q.delete();
  endtask

  initial begin
    int start;
    int blob_no;
    int sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_BYTES[i]) push_byte(DIRECTED_BYTES[i]);
    send_blob(1'b1);

    tx_idle = 1'b0;
    rx_idle = 1'b0;

    // long output hold-off while the sender keeps pushing bytes
    start    = sent_count;
    hold_req = 1'b1;
    add_many_actions();
    send_blob(1'b1);

    blob_no = 0;
    while (sent_count < start + RANDOM_ITEMS) begin
      sel = (blob_no < 6) ? blob_no : int'($urandom_range(0, 19));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      case (sel)
        0: add_deep(1'b1);
        1: add_deep(blob_no == 1 ? 1'b0 : 1'($urandom));
        2: add_many_actions();
        3: add_many_strings();
        4, 6: add_noise();
        default: add_wellformed();
      endcase
      send_blob(blob_no < 6 || $urandom_range(0, 9) != 0);
      blob_no++;
    end
    in_tvalid <= 1'b0;

    rx_idle = 1'b1;
    for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending != 0) $error("results missing at end: %0d", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
